// ----- src/sfla_pkg.sv -----
// Shared types and constants of the segregated free-list allocator.
`timescale 1ns / 1ps
`default_nettype none
package sfla_pkg;

	localparam int HEAP_BYTES   = 4096;
	localparam int HEADER_BYTES = 16;
	localparam int OFF_W        = 12;
	localparam int IDX_W        = 9;
	localparam int SIZE_W       = 13;
	localparam int TAG_DEPTH    = 512;
	localparam int BIG_BYTES    = HEAP_BYTES - 2 * HEADER_BYTES;
	localparam logic [IDX_W-1:0] MID_IDX    = IDX_W'(HEADER_BYTES / 8);
	localparam logic [IDX_W-1:0] RFENCE_IDX = IDX_W'((HEAP_BYTES - HEADER_BYTES) / 8);
	localparam int NPROG = 7;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_NULL   = 2'd1;
	localparam logic [1:0] STATUS_NOMEM  = 2'd2;
	localparam logic [1:0] STATUS_DOUBLE = 2'd3;

	typedef enum logic [1:0] {
		TS_FREE  = 2'd0,
		TS_USED  = 2'd1,
		TS_FENCE = 2'd2
	} tstate_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_SIZE,
		OP_LEFT,
		OP_CLRSTART,
		OP_USED,
		OP_REMOVE,
		OP_INSERT
	} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		logic [IDX_W-1:0] addr;
		logic [SIZE_W-1:0] val;
	} op_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SRCH_HEAD,
		ST_SRCH_TAG,
		ST_FREE_SELF,
		ST_FREE_LEFT,
		ST_FREE_RIGHT,
		ST_PLAN,
		ST_PATCH,
		ST_RM_SELF,
		ST_RM_PREV,
		ST_RM_NEXT,
		ST_RM_FIN,
		ST_INS_SELF,
		ST_INS_HEAD,
		ST_INS_NEIGH,
		ST_INS_FIN,
		ST_DONE
	} state_t;

	function automatic op_t mk_op(input op_kind_t kind, input logic [IDX_W-1:0] addr,
		input logic [SIZE_W-1:0] val);
		op_t o;
		o.kind = kind;
		o.addr = addr;
		o.val = val;
		return o;
	endfunction

endpackage
`default_nettype wire

// ----- src/segregated_freelist_allocator_top.sv -----
// Heap allocator with boundary tags and segregated free lists held in block RAM.
// Allocation searches the lists from the request's class upward past empty lists and too small
// heads, walking blocks only on the last list, then patches tags and unlinks or links blocks.
// A free reads its own and its neighbours' tags; zero or misaligned requests end at once.
// One request is in work at a time; the next is taken the cycle after a result is loaded.
// After reset a clearing pass writes the initial tags to all 512 tag entries and the list heads.
`timescale 1ns / 1ps
`default_nettype none
module segregated_freelist_allocator_top #(
	parameter int FREE_LISTS      = 59,
	parameter int MIN_BLOCK_BYTES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        action,
	input  wire logic [15:0] request_bytes,
	input  wire logic [11:0] block_address,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [11:0]      data_address
);

	localparam int LW = $clog2(FREE_LISTS);
	localparam int IW = sfla_pkg::IDX_W;
	localparam int SW = sfla_pkg::SIZE_W;
	localparam int OW = sfla_pkg::OFF_W;
	localparam logic [LW-1:0] LAST = LW'(FREE_LISTS - 1);
	localparam int BIG_Q = sfla_pkg::BIG_BYTES / 8 - 3;
	localparam logic [LW-1:0] BIG_CLASS = LW'((BIG_Q >= FREE_LISTS) ? FREE_LISTS - 1 : BIG_Q);

	typedef struct packed {
		logic [SW-1:0] size;
		logic [SW-1:0] left;
		logic [IW-1:0] next;
		logic [IW-1:0] prev;
		sfla_pkg::tstate_t tst;
		logic [LW-1:0] lnum;
		logic start;
	} tag_t;

	function automatic logic [LW-1:0] class_of(input logic [17:0] size);
		logic [14:0] q;
		logic [LW-1:0] r;
		q = size[17:3];
		if (q < 15'd3) begin
			r = '0;
		end else if (q - 15'd3 >= 15'(FREE_LISTS)) begin
			r = LAST;
		end else begin
			r = LW'(q - 15'd3);
		end
		return r;
	endfunction

	tag_t tmem [sfla_pkg::TAG_DEPTH];
	logic [IW-1:0] hmem [FREE_LISTS];

	tag_t t_rdata_q, t_wdata;
	logic [IW-1:0] t_raddr, t_waddr;
	logic t_we;
	logic [IW-1:0] h_rdata_q, h_wdata;
	logic [LW-1:0] h_raddr, h_waddr;
	logic h_we;

	sfla_pkg::state_t state_q, state_d;
	logic [IW-1:0] clr_q, clr_d;
	sfla_pkg::op_t prog_q [sfla_pkg::NPROG];
	sfla_pkg::op_t prog_d [sfla_pkg::NPROG];
	sfla_pkg::op_t op_q, op_d;
	logic out_valid_q;
	logic [1:0] status_q;
	logic [11:0] data_address_q;

	logic [17:0] total_q, total_d;
	logic [LW-1:0] lst_q, lst_d;
	logic [IW-1:0] cur_q, cur_d, b_q, b_d, lb_q, lb_d, rb_q, rb_d, nb_q, nb_d;
	tag_t tag_q, tag_d;
	logic [SW-1:0] cs_q, cs_d, ls_q, ls_d;
	logic lfree_q, lfree_d;
	logic [1:0] res_status_q, res_status_d;
	logic [11:0] res_addr_q, res_addr_d;
	logic load_out;

	logic [17:0] req_round, req_raw, req_total;
	logic [11:0] fb_byte;
	logic [SW-1:0] split_rem;
	logic [IW-1:0] hi_idx, succ_idx;
	logic fits;
	logic [OW-1:0] self_byte, lb_byte;
	logic [IW-1:0] lb_idx, rb_idx;
	logic [OW+1:0] rb_sum;
	logic rfree;
	logic [SW-1:0] m_both, m_right, m_left;

	assign req_round = ({2'b00, request_bytes} + 18'd7) & ~18'd7;
	assign req_raw = req_round + 18'(sfla_pkg::HEADER_BYTES);
	assign req_total = (req_raw < 18'(MIN_BLOCK_BYTES)) ? 18'(MIN_BLOCK_BYTES) : req_raw;
	assign fb_byte = block_address - 12'(sfla_pkg::HEADER_BYTES);
	assign split_rem = t_rdata_q.size - total_q[SW-1:0];
	assign hi_idx = cur_q + split_rem[IW+2:3];
	assign succ_idx = cur_q + t_rdata_q.size[IW+2:3];
	assign fits = {5'b00000, t_rdata_q.size} >= total_q;
	assign self_byte = {b_q, 3'b000};
	assign lb_byte = self_byte - t_rdata_q.left[OW-1:0];
	assign lb_idx = ({1'b0, self_byte} >= t_rdata_q.left) ? lb_byte[OW-1:3] : '0;
	assign rb_sum = {2'b00, self_byte} + {1'b0, t_rdata_q.size};
	assign rb_idx = (rb_sum >= 14'(sfla_pkg::HEAP_BYTES)) ? sfla_pkg::RFENCE_IDX
		: rb_sum[OW-1:3];
	assign rfree = t_rdata_q.start && (t_rdata_q.tst == sfla_pkg::TS_FREE) && (rb_q != b_q);
	assign m_both = ls_q + cs_q + t_rdata_q.size;
	assign m_right = cs_q + t_rdata_q.size;
	assign m_left = ls_q + cs_q;
	assign load_out = (state_q == sfla_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk) begin
		t_rdata_q <= tmem[t_raddr];
		if (t_we) begin
			tmem[t_waddr] <= t_wdata;
		end
		h_rdata_q <= hmem[h_raddr];
		if (h_we) begin
			hmem[h_waddr] <= h_wdata;
		end
	end

	always_comb begin
		tag_t tw;
		state_d = state_q;
		clr_d = clr_q;
		prog_d = prog_q;
		op_d = op_q;
		total_d = total_q;
		lst_d = lst_q;
		cur_d = cur_q;
		b_d = b_q;
		lb_d = lb_q;
		rb_d = rb_q;
		nb_d = nb_q;
		tag_d = tag_q;
		cs_d = cs_q;
		ls_d = ls_q;
		lfree_d = lfree_q;
		res_status_d = res_status_q;
		res_addr_d = res_addr_q;
		t_raddr = '0;
		t_we = 1'b0;
		t_waddr = '0;
		t_wdata = '0;
		h_raddr = '0;
		h_we = 1'b0;
		h_waddr = '0;
		h_wdata = '0;
		tw = t_rdata_q;
		in_stall = 1'b1;
		case (state_q)
			sfla_pkg::ST_CLEAR: begin
				tw = '0;
				if (clr_q == '0) begin
					tw.tst = sfla_pkg::TS_FENCE;
					tw.size = SW'(sfla_pkg::HEADER_BYTES);
					tw.left = SW'(sfla_pkg::HEADER_BYTES);
					tw.start = 1'b1;
				end else if (clr_q == sfla_pkg::MID_IDX) begin
					tw.tst = sfla_pkg::TS_FREE;
					tw.size = SW'(sfla_pkg::BIG_BYTES);
					tw.left = SW'(sfla_pkg::HEADER_BYTES);
					tw.lnum = BIG_CLASS;
					tw.start = 1'b1;
				end else if (clr_q == sfla_pkg::RFENCE_IDX) begin
					tw.tst = sfla_pkg::TS_FENCE;
					tw.size = SW'(sfla_pkg::HEADER_BYTES);
					tw.left = SW'(sfla_pkg::BIG_BYTES);
					tw.start = 1'b1;
				end
				t_we = 1'b1;
				t_waddr = clr_q;
				t_wdata = tw;
				if ({1'b0, clr_q} < 10'(FREE_LISTS)) begin
					h_we = 1'b1;
					h_waddr = clr_q[LW-1:0];
					h_wdata = (clr_q[LW-1:0] == BIG_CLASS) ? sfla_pkg::MID_IDX : '0;
				end
				clr_d = clr_q + 1'b1;
				if (&clr_q) begin
					state_d = sfla_pkg::ST_IDLE;
				end
			end
			sfla_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					res_addr_d = '0;
					if (action == sfla_pkg::ACT_ALLOC) begin
						if (request_bytes == '0) begin
							res_status_d = sfla_pkg::STATUS_NULL;
							state_d = sfla_pkg::ST_DONE;
						end else begin
							total_d = req_total;
							lst_d = class_of(req_total);
							h_raddr = class_of(req_total);
							state_d = sfla_pkg::ST_SRCH_HEAD;
						end
					end else if (block_address < 12'(sfla_pkg::HEADER_BYTES)
						|| fb_byte[2:0] != 3'b000) begin
						res_status_d = sfla_pkg::STATUS_NULL;
						state_d = sfla_pkg::ST_DONE;
					end else begin
						b_d = fb_byte[OW-1:3];
						t_raddr = fb_byte[OW-1:3];
						state_d = sfla_pkg::ST_FREE_SELF;
					end
				end
			end
			sfla_pkg::ST_SRCH_HEAD: begin
				if (h_rdata_q == '0) begin
					if (lst_q == LAST) begin
						res_status_d = sfla_pkg::STATUS_NOMEM;
						state_d = sfla_pkg::ST_DONE;
					end else begin
						lst_d = lst_q + 1'b1;
						h_raddr = lst_q + 1'b1;
					end
				end else begin
					cur_d = h_rdata_q;
					t_raddr = h_rdata_q;
					state_d = sfla_pkg::ST_SRCH_TAG;
				end
			end
			sfla_pkg::ST_SRCH_TAG: begin
				if (fits) begin
					for (int i = 0; i < sfla_pkg::NPROG; i++) begin
						prog_d[i] = '0;
					end
					res_status_d = sfla_pkg::STATUS_OK;
					if (split_rem < SW'(MIN_BLOCK_BYTES)) begin
						prog_d[0] = sfla_pkg::mk_op(sfla_pkg::OP_REMOVE, cur_q, '0);
						prog_d[1] = sfla_pkg::mk_op(sfla_pkg::OP_USED, cur_q, '0);
						res_addr_d = {cur_q, 3'b000} + 12'(sfla_pkg::HEADER_BYTES);
					end else begin
						tw = '0;
						tw.size = total_q[SW-1:0];
						tw.left = split_rem;
						tw.tst = sfla_pkg::TS_USED;
						tw.start = 1'b1;
						t_we = 1'b1;
						t_waddr = hi_idx;
						t_wdata = tw;
						prog_d[0] = sfla_pkg::mk_op(sfla_pkg::OP_SIZE, cur_q, split_rem);
						prog_d[1] = sfla_pkg::mk_op(sfla_pkg::OP_LEFT, succ_idx,
							total_q[SW-1:0]);
						if (class_of({5'b00000, split_rem})
							!= class_of({5'b00000, t_rdata_q.size})) begin
							prog_d[2] = sfla_pkg::mk_op(sfla_pkg::OP_REMOVE, cur_q, '0);
							prog_d[3] = sfla_pkg::mk_op(sfla_pkg::OP_INSERT, cur_q, '0);
						end
						res_addr_d = {hi_idx, 3'b000} + 12'(sfla_pkg::HEADER_BYTES);
					end
					state_d = sfla_pkg::ST_PLAN;
				end else if (lst_q != LAST) begin
					lst_d = lst_q + 1'b1;
					h_raddr = lst_q + 1'b1;
					state_d = sfla_pkg::ST_SRCH_HEAD;
				end else if (t_rdata_q.next == '0) begin
					res_status_d = sfla_pkg::STATUS_NOMEM;
					state_d = sfla_pkg::ST_DONE;
				end else begin
					cur_d = t_rdata_q.next;
					t_raddr = t_rdata_q.next;
				end
			end
			sfla_pkg::ST_FREE_SELF: begin
				if (!t_rdata_q.start || t_rdata_q.tst == sfla_pkg::TS_FENCE) begin
					res_status_d = sfla_pkg::STATUS_NULL;
					state_d = sfla_pkg::ST_DONE;
				end else if (t_rdata_q.tst == sfla_pkg::TS_FREE) begin
					res_status_d = sfla_pkg::STATUS_DOUBLE;
					state_d = sfla_pkg::ST_DONE;
				end else begin
					tw.tst = sfla_pkg::TS_FREE;
					t_we = 1'b1;
					t_waddr = b_q;
					t_wdata = tw;
					cs_d = t_rdata_q.size;
					lb_d = lb_idx;
					rb_d = rb_idx;
					t_raddr = lb_idx;
					state_d = sfla_pkg::ST_FREE_LEFT;
				end
			end
			sfla_pkg::ST_FREE_LEFT: begin
				lfree_d = t_rdata_q.start && (t_rdata_q.tst == sfla_pkg::TS_FREE)
					&& (lb_q != b_q);
				ls_d = t_rdata_q.size;
				t_raddr = rb_q;
				state_d = sfla_pkg::ST_FREE_RIGHT;
			end
			sfla_pkg::ST_FREE_RIGHT: begin
				for (int i = 0; i < sfla_pkg::NPROG; i++) begin
					prog_d[i] = '0;
				end
				res_status_d = sfla_pkg::STATUS_OK;
				if (!lfree_q && !rfree) begin
					prog_d[0] = sfla_pkg::mk_op(sfla_pkg::OP_LEFT, rb_q, cs_q);
					prog_d[1] = sfla_pkg::mk_op(sfla_pkg::OP_INSERT, b_q, '0);
				end else if (lfree_q && rfree) begin
					prog_d[0] = sfla_pkg::mk_op(sfla_pkg::OP_REMOVE, rb_q, '0);
					prog_d[1] = sfla_pkg::mk_op(sfla_pkg::OP_SIZE, lb_q, m_both);
					prog_d[2] = sfla_pkg::mk_op(sfla_pkg::OP_LEFT, lb_q + m_both[IW+2:3],
						m_both);
					prog_d[3] = sfla_pkg::mk_op(sfla_pkg::OP_CLRSTART, b_q, '0);
					prog_d[4] = sfla_pkg::mk_op(sfla_pkg::OP_CLRSTART, rb_q, '0);
					if (class_of({5'b00000, m_both}) != class_of({5'b00000, ls_q})) begin
						prog_d[5] = sfla_pkg::mk_op(sfla_pkg::OP_REMOVE, lb_q, '0);
						prog_d[6] = sfla_pkg::mk_op(sfla_pkg::OP_INSERT, lb_q, '0);
					end
				end else if (rfree) begin
					prog_d[0] = sfla_pkg::mk_op(sfla_pkg::OP_REMOVE, rb_q, '0);
					prog_d[1] = sfla_pkg::mk_op(sfla_pkg::OP_CLRSTART, rb_q, '0);
					prog_d[2] = sfla_pkg::mk_op(sfla_pkg::OP_SIZE, b_q, m_right);
					prog_d[3] = sfla_pkg::mk_op(sfla_pkg::OP_LEFT, b_q + m_right[IW+2:3],
						m_right);
					prog_d[4] = sfla_pkg::mk_op(sfla_pkg::OP_INSERT, b_q, '0);
				end else begin
					prog_d[0] = sfla_pkg::mk_op(sfla_pkg::OP_SIZE, lb_q, m_left);
					prog_d[1] = sfla_pkg::mk_op(sfla_pkg::OP_LEFT, rb_q, m_left);
					prog_d[2] = sfla_pkg::mk_op(sfla_pkg::OP_CLRSTART, b_q, '0);
					if (class_of({5'b00000, m_left}) != class_of({5'b00000, ls_q})) begin
						prog_d[3] = sfla_pkg::mk_op(sfla_pkg::OP_REMOVE, lb_q, '0);
						prog_d[4] = sfla_pkg::mk_op(sfla_pkg::OP_INSERT, lb_q, '0);
					end
				end
				state_d = sfla_pkg::ST_PLAN;
			end
			sfla_pkg::ST_PLAN: begin
				op_d = prog_q[0];
				for (int i = 0; i < sfla_pkg::NPROG - 1; i++) begin
					prog_d[i] = prog_q[i+1];
				end
				prog_d[sfla_pkg::NPROG-1] = '0;
				t_raddr = prog_q[0].addr;
				case (prog_q[0].kind)
					sfla_pkg::OP_NONE: state_d = sfla_pkg::ST_DONE;
					sfla_pkg::OP_REMOVE: state_d = sfla_pkg::ST_RM_SELF;
					sfla_pkg::OP_INSERT: state_d = sfla_pkg::ST_INS_SELF;
					default: state_d = sfla_pkg::ST_PATCH;
				endcase
			end
			sfla_pkg::ST_PATCH: begin
				case (op_q.kind)
					sfla_pkg::OP_SIZE: tw.size = op_q.val;
					sfla_pkg::OP_LEFT: tw.left = op_q.val;
					sfla_pkg::OP_CLRSTART: tw.start = 1'b0;
					sfla_pkg::OP_USED: tw.tst = sfla_pkg::TS_USED;
					default: tw = t_rdata_q;
				endcase
				t_we = 1'b1;
				t_waddr = op_q.addr;
				t_wdata = tw;
				state_d = sfla_pkg::ST_PLAN;
			end
			sfla_pkg::ST_RM_SELF: begin
				tag_d = t_rdata_q;
				if (t_rdata_q.prev == '0) begin
					h_we = 1'b1;
					h_waddr = t_rdata_q.lnum;
					h_wdata = t_rdata_q.next;
				end else begin
					t_raddr = t_rdata_q.prev;
				end
				state_d = sfla_pkg::ST_RM_PREV;
			end
			sfla_pkg::ST_RM_PREV: begin
				if (tag_q.prev != '0) begin
					tw.next = tag_q.next;
					t_we = 1'b1;
					t_waddr = tag_q.prev;
					t_wdata = tw;
				end
				if (tag_q.next != '0) begin
					t_raddr = tag_q.next;
					state_d = sfla_pkg::ST_RM_NEXT;
				end else begin
					state_d = sfla_pkg::ST_RM_FIN;
				end
			end
			sfla_pkg::ST_RM_NEXT: begin
				tw.prev = tag_q.prev;
				t_we = 1'b1;
				t_waddr = tag_q.next;
				t_wdata = tw;
				state_d = sfla_pkg::ST_RM_FIN;
			end
			sfla_pkg::ST_RM_FIN: begin
				tw = tag_q;
				tw.next = '0;
				tw.prev = '0;
				t_we = 1'b1;
				t_waddr = op_q.addr;
				t_wdata = tw;
				state_d = sfla_pkg::ST_PLAN;
			end
			sfla_pkg::ST_INS_SELF: begin
				tag_d = t_rdata_q;
				lst_d = class_of({5'b00000, t_rdata_q.size});
				h_raddr = class_of({5'b00000, t_rdata_q.size});
				state_d = sfla_pkg::ST_INS_HEAD;
			end
			sfla_pkg::ST_INS_HEAD: begin
				nb_d = h_rdata_q;
				h_we = 1'b1;
				h_waddr = lst_q;
				h_wdata = op_q.addr;
				if (h_rdata_q != '0) begin
					t_raddr = h_rdata_q;
					state_d = sfla_pkg::ST_INS_NEIGH;
				end else begin
					state_d = sfla_pkg::ST_INS_FIN;
				end
			end
			sfla_pkg::ST_INS_NEIGH: begin
				tw.prev = op_q.addr;
				t_we = 1'b1;
				t_waddr = nb_q;
				t_wdata = tw;
				state_d = sfla_pkg::ST_INS_FIN;
			end
			sfla_pkg::ST_INS_FIN: begin
				tw = tag_q;
				tw.lnum = lst_q;
				tw.prev = '0;
				tw.next = nb_q;
				t_we = 1'b1;
				t_waddr = op_q.addr;
				t_wdata = tw;
				state_d = sfla_pkg::ST_PLAN;
			end
			sfla_pkg::ST_DONE: begin
				if (load_out) begin
					state_d = sfla_pkg::ST_IDLE;
				end
			end
			default: state_d = sfla_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfla_pkg::ST_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < sfla_pkg::NPROG; i++) begin
				prog_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			clr_q <= clr_d;
			prog_q <= prog_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q <= op_d;
		total_q <= total_d;
		lst_q <= lst_d;
		cur_q <= cur_d;
		b_q <= b_d;
		lb_q <= lb_d;
		rb_q <= rb_d;
		nb_q <= nb_d;
		tag_q <= tag_d;
		cs_q <= cs_d;
		ls_q <= ls_d;
		lfree_q <= lfree_d;
		res_status_q <= res_status_d;
		res_addr_q <= res_addr_d;
		if (load_out) begin
			status_q <= res_status_q;
			data_address_q <= res_addr_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign data_address = data_address_q;

endmodule
`default_nettype wire

// ----- dv/segregated_freelist_allocator_checker.sv -----
// Checker of the allocator: predicts each request's result and compares it with the output.
`timescale 1ns / 1ps
module segregated_freelist_allocator_checker #(
	parameter int FREE_LISTS      = 59,
	parameter int MIN_BLOCK_BYTES = 32
) (
	input  wire logic        clk,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic        action,
	input  wire logic [15:0] request_bytes,
	input  wire logic [11:0] block_address,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [1:0]  status,
	input  wire logic [11:0] data_address,
	output int               errors,
	output int               pending
);

	typedef struct {
		logic [1:0]  status;
		logic [11:0] addr;
	} heap_result_t;

	localparam int unsigned NIL = 0;
	localparam int unsigned HEAP = sfla_pkg::HEAP_BYTES;
	localparam int unsigned HDR = sfla_pkg::HEADER_BYTES;

	int unsigned tag_size [HEAP];
	int unsigned tag_left [HEAP];
	int unsigned tag_next [HEAP];
	int unsigned tag_prev [HEAP];
	sfla_pkg::tstate_t tag_state [HEAP];
	int unsigned tag_list [HEAP];
	bit          tag_start [HEAP];
	int unsigned heads [FREE_LISTS];

	heap_result_t awaited[$];

	function automatic int unsigned size_class(int unsigned size);
		int unsigned q;
		q = size / 8;
		if (q < 3) return 0;
		q -= 3;
		if (q >= FREE_LISTS) q = FREE_LISTS - 1;
		return q;
	endfunction

	task automatic unlink(int unsigned b);
		int unsigned n, p, l;
		n = tag_next[b];
		p = tag_prev[b];
		l = tag_list[b];
		if (p == NIL) begin
			if (l < FREE_LISTS) heads[l] = n;
		end else if (p < HEAP) begin
			tag_next[p] = n;
		end
		if (n != NIL && n < HEAP) tag_prev[n] = p;
		tag_next[b] = NIL;
		tag_prev[b] = NIL;
	endtask

	task automatic link_head(int unsigned b);
		int unsigned l, h;
		l = size_class(tag_size[b]);
		h = heads[l];
		tag_list[b] = l;
		tag_prev[b] = NIL;
		tag_next[b] = h;
		if (h != NIL && h < HEAP) tag_prev[h] = b;
		heads[l] = b;
	endtask

	task automatic set_left(int unsigned b, int unsigned v);
		if (b < HEAP) tag_left[b] = v;
	endtask

	task automatic heap_reset();
		for (int i = 0; i < HEAP; i++) begin
			tag_size[i] = 0;
			tag_left[i] = 0;
			tag_next[i] = 0;
			tag_prev[i] = 0;
			tag_state[i] = sfla_pkg::TS_FREE;
			tag_list[i] = 0;
			tag_start[i] = 0;
		end
		for (int i = 0; i < FREE_LISTS; i++) heads[i] = NIL;
		tag_state[0] = sfla_pkg::TS_FENCE;
		tag_size[0] = HDR;
		tag_left[0] = HDR;
		tag_start[0] = 1;
		tag_size[HDR] = sfla_pkg::BIG_BYTES;
		tag_left[HDR] = HDR;
		tag_start[HDR] = 1;
		tag_state[HEAP - HDR] = sfla_pkg::TS_FENCE;
		tag_size[HEAP - HDR] = HDR;
		tag_left[HEAP - HDR] = sfla_pkg::BIG_BYTES;
		tag_start[HEAP - HDR] = 1;
		link_head(HDR);
	endtask

	task automatic allocate(int unsigned req, output heap_result_t r);
		int unsigned total, cur, rem, hi, c, steps, old_class;
		bit found;
		r.status = sfla_pkg::STATUS_OK;
		r.addr = '0;
		found = 0;
		cur = NIL;
		if (req == 0) begin
			r.status = sfla_pkg::STATUS_NULL;
			return;
		end
		total = ((req + 7) & ~32'd7) + HDR;
		if (total < MIN_BLOCK_BYTES) total = MIN_BLOCK_BYTES;
		for (int unsigned l = size_class(total); l < FREE_LISTS && !found; l++) begin
			c = heads[l];
			steps = 0;
			while (c != NIL && c < HEAP && steps < HEAP) begin
				if (tag_size[c] >= total) begin
					cur = c;
					found = 1;
					break;
				end
				if (l != FREE_LISTS - 1) break;
				c = tag_next[c];
				steps++;
			end
		end
		if (!found) begin
			r.status = sfla_pkg::STATUS_NOMEM;
			return;
		end
		rem = tag_size[cur] - total;
		if (rem < MIN_BLOCK_BYTES) begin
			unlink(cur);
			tag_state[cur] = sfla_pkg::TS_USED;
			r.addr = 12'(cur + HDR);
			return;
		end
		hi = cur + rem;
		if (hi >= HEAP) begin
			r.status = sfla_pkg::STATUS_NOMEM;
			return;
		end
		old_class = size_class(tag_size[cur]);
		tag_size[hi] = total;
		tag_left[hi] = rem;
		tag_state[hi] = sfla_pkg::TS_USED;
		tag_start[hi] = 1;
		tag_next[hi] = NIL;
		tag_prev[hi] = NIL;
		tag_size[cur] = rem;
		if (size_class(rem) != old_class) begin
			unlink(cur);
			link_head(cur);
		end
		set_left(hi + total, total);
		r.addr = 12'(hi + HDR);
	endtask

	task automatic release_block(int unsigned addr, output heap_result_t r);
		int unsigned b, lb, rb, cs, ls, rs, merged, old_class;
		bit lfree, rfree;
		r.status = sfla_pkg::STATUS_OK;
		r.addr = '0;
		if (addr < HDR) begin
			r.status = sfla_pkg::STATUS_NULL;
			return;
		end
		b = addr - HDR;
		if (b >= HEAP || !tag_start[b] || tag_state[b] == sfla_pkg::TS_FENCE) begin
			r.status = sfla_pkg::STATUS_NULL;
			return;
		end
		if (tag_state[b] == sfla_pkg::TS_FREE) begin
			r.status = sfla_pkg::STATUS_DOUBLE;
			return;
		end
		cs = tag_size[b];
		lb = (tag_left[b] <= b) ? b - tag_left[b] : 0;
		rb = b + cs;
		if (rb >= HEAP) rb = HEAP - HDR;
		tag_state[b] = sfla_pkg::TS_FREE;
		lfree = tag_start[lb] && tag_state[lb] == sfla_pkg::TS_FREE && lb != b;
		rfree = tag_start[rb] && tag_state[rb] == sfla_pkg::TS_FREE && rb != b;
		ls = tag_size[lb];
		rs = tag_size[rb];
		if (!lfree && !rfree) begin
			set_left(rb, cs);
			link_head(b);
		end else if (lfree && rfree) begin
			old_class = size_class(ls);
			merged = ls + cs + rs;
			unlink(rb);
			tag_size[lb] = merged;
			set_left(lb + merged, merged);
			tag_start[b] = 0;
			tag_start[rb] = 0;
			if (size_class(merged) != old_class) begin
				unlink(lb);
				link_head(lb);
			end
		end else if (rfree) begin
			merged = cs + rs;
			unlink(rb);
			tag_start[rb] = 0;
			tag_size[b] = merged;
			set_left(b + merged, merged);
			link_head(b);
		end else begin
			old_class = size_class(ls);
			merged = ls + cs;
			tag_size[lb] = merged;
			set_left(rb, merged);
			tag_start[b] = 0;
			if (size_class(merged) != old_class) begin
				unlink(lb);
				link_head(lb);
			end
		end
	endtask

	task automatic report(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
		heap_reset();
	end

	always @(posedge clk) begin
		heap_result_t r, e;
		if (in_valid && !in_stall) begin
			if (action == sfla_pkg::ACT_ALLOC) allocate(request_bytes, r);
			else release_block(block_address, r);
			awaited.push_back(r);
		end
		if (out_valid && !out_stall) begin
			if (awaited.size() == 0) begin
				report($sformatf("unexpected result status %0d address %0d", status,
					data_address));
			end else begin
				e = awaited.pop_front();
				if (status !== e.status)
					report($sformatf("status %0d, predicted %0d", status, e.status));
				if (data_address !== e.addr)
					report($sformatf("data_address %0d, predicted %0d", data_address,
						e.addr));
			end
		end
		pending = awaited.size();
	end

endmodule

// ----- dv/segregated_freelist_allocator_top_tb.sv -----
// Testbench top of the allocator: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps
module segregated_freelist_allocator_top_tb;

	localparam int CYCLE_LIMIT = 6000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        action = sfla_pkg::ACT_ALLOC;
	logic [15:0] request_bytes = '0;
	logic [11:0] block_address = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [11:0] data_address;
	int          errors;
	int          pending;
	int          cycles = 0;
	int          hold_cnt = 0;
	bit          quiet = 0;

	logic [11:0] live[$];
	logic [11:0] released[$];

	segregated_freelist_allocator_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .request_bytes(request_bytes), .block_address(block_address),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .data_address(data_address)
	);

	segregated_freelist_allocator_checker u_chk (
		.clk(clk), .in_valid(in_valid), .in_stall(in_stall), .action(action),
		.request_bytes(request_bytes), .block_address(block_address),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.data_address(data_address), .errors(errors), .pending(pending)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			out_stall <= 1'b1;
			hold_cnt <= hold_cnt - 1;
		end else begin
			out_stall <= !quiet && ($urandom_range(0, 99) < 6);
		end
		if (out_valid && !out_stall && status == sfla_pkg::STATUS_OK && data_address != 0)
			live.push_back(data_address);
	end

	task automatic send(logic act, logic [15:0] req, logic [11:0] addr);
		action <= act;
		request_bytes <= req;
		block_address <= addr;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (!quiet && $urandom_range(0, 99) < 6) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic free_live();
		int k;
		logic [11:0] a;
		k = $urandom_range(0, live.size() - 1);
		a = live[k];
		live.delete(k);
		released.push_back(a);
		if (released.size() > 32) void'(released.pop_front());
		send(sfla_pkg::ACT_FREE, '0, a);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic random_request();
		int p;
		logic [15:0] sz;
		p = $urandom_range(0, 99);
		if (live.size() > 0 && p < 45) begin
			p = $urandom_range(0, 99);
			if (p < 80 || released.size() == 0) free_live();
			else if (p < 90) send(sfla_pkg::ACT_FREE, 16'($urandom),
				released[$urandom_range(0, released.size() - 1)]);
			else send(sfla_pkg::ACT_FREE, 16'($urandom), 12'($urandom));
		end else begin
			p = $urandom_range(0, 99);
			if (p < 70) sz = 16'($urandom_range(1, 120));
			else if (p < 90) sz = 16'($urandom_range(121, 1000));
			else if (p < 95) sz = 16'($urandom_range(1001, 4080));
			else if (p < 98) sz = 16'($urandom);
			else sz = '0;
			send(sfla_pkg::ACT_ALLOC, sz, 12'($urandom));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(sfla_pkg::ACT_ALLOC, 16'd0, 12'hfff);
		send(sfla_pkg::ACT_ALLOC, 16'hffff, 12'd0);
		send(sfla_pkg::ACT_ALLOC, 16'd4064, 12'd0);
		send(sfla_pkg::ACT_ALLOC, 16'd4048, 12'd0);
		drain();
		if (live.size() > 0) free_live();
		send(sfla_pkg::ACT_FREE, '0, 12'd0);
		send(sfla_pkg::ACT_FREE, '0, 12'd15);
		send(sfla_pkg::ACT_FREE, '0, 12'hfff);
		send(sfla_pkg::ACT_FREE, '0, 12'd4080);
		send(sfla_pkg::ACT_FREE, '0, 12'd16);
		send(sfla_pkg::ACT_FREE, '0, 12'd40);
		send(sfla_pkg::ACT_ALLOC, 16'd1, 12'd0);
		send(sfla_pkg::ACT_ALLOC, 16'd8, 12'd0);
		send(sfla_pkg::ACT_ALLOC, 16'd9, 12'd0);
		send(sfla_pkg::ACT_ALLOC, 16'd24, 12'd0);
		send(sfla_pkg::ACT_ALLOC, 16'd100, 12'd0);
		send(sfla_pkg::ACT_ALLOC, 16'd480, 12'd0);
		send(sfla_pkg::ACT_ALLOC, 16'd40, 12'd0);
		drain();
		while (live.size() > 0) free_live();
		drain();

		for (int i = 0; i < 1700; i++) begin
			quiet = (i >= 400 && i < 700);
			if (i == 900) begin
				@(posedge clk);
				hold_cnt <= 400;
			end
			if (i == 1300) drain();
			random_request();
		end
		drain();
		repeat (60) @(posedge clk);

		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
